### sv/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Types, codes and sizes shared by the block word deframer modules.
// ----------------------------------------------------------------------------
package dfr_pkg;

    // width of the internal sample counter
    localparam int COUNT_BITS  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // parser states
    localparam logic [3:0] ST_BLK_HDR      = 4'd0;
    localparam logic [3:0] ST_EVT_HDR      = 4'd1;
    localparam logic [3:0] ST_TRIG1        = 4'd2;
    localparam logic [3:0] ST_TRIG2        = 4'd3;
    localparam logic [3:0] ST_FRAME_OR_END = 4'd4;
    localparam logic [3:0] ST_IN_FRAME     = 4'd5;
    localparam logic [3:0] ST_DATA_TRL     = 4'd6;
    localparam logic [3:0] ST_FILLER       = 4'd7;
    localparam logic [3:0] ST_DROP         = 4'd8;

    // record kinds
    localparam logic [2:0] KIND_EVENT  = 3'd0;
    localparam logic [2:0] KIND_TRIG1  = 3'd1;
    localparam logic [2:0] KIND_TRIG2  = 3'd2;
    localparam logic [2:0] KIND_FINE   = 3'd3;
    localparam logic [2:0] KIND_SAMPLE = 3'd4;
    localparam logic [2:0] KIND_OK     = 3'd5;
    localparam logic [2:0] KIND_ERR    = 3'd6;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_BLK_HDR   = 4'd1;
    localparam logic [3:0] ERR_EVT_HDR   = 4'd2;
    localparam logic [3:0] ERR_TRIG1     = 4'd3;
    localparam logic [3:0] ERR_TRIG2     = 4'd4;
    localparam logic [3:0] ERR_FRAME_HDR = 4'd5;
    localparam logic [3:0] ERR_FRAME_TRL = 4'd6;
    localparam logic [3:0] ERR_DATA_TRL  = 4'd7;
    localparam logic [3:0] ERR_EVT_TRL   = 4'd8;
    localparam logic [3:0] ERR_BLK_TRL   = 4'd9;
    localparam logic [3:0] ERR_TRUNC     = 4'd10;

    localparam logic [23:0] FILLER_WORD = 24'hE00000;

    typedef struct packed {
        logic [23:0] word;
        logic        buffer_end;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [12:0] channel;
        logic [19:0] value;
        logic [3:0]  error_code;
        logic [15:0] word_count;
        logic        last;
    } out_item_t;

    // one queued transaction: optional data record, optional buffer summary
    typedef struct packed {
        logic        rec_valid;
        logic [2:0]  rec_kind;
        logic [12:0] rec_channel;
        logic [19:0] rec_value;
        logic        sum_valid;
        logic [3:0]  sum_code;
        logic [15:0] sum_count;
    } dfr_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } dfr_qstat_t;

endpackage

### sv/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Framing parser: accepts readout words, tracks block/event/frame state and
// queues the records each word produces.
// ----------------------------------------------------------------------------
module dfr_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                word_valid,
    output logic                word_ready,
    input  dfr_pkg::in_item_t   word_item,
    input  dfr_pkg::dfr_qstat_t q_stat,
    output logic                push,
    output dfr_pkg::dfr_entry_t push_entry
);
    import dfr_pkg::*;

    logic [3:0]            state_reg, state_next;
    logic [4:0]            module_id_reg, module_id_next;
    logic [7:0]            events_left_reg, events_left_next;
    logic [3:0]            adc_reg, adc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [3:0]            err_reg, err_next;

    logic        accept;
    logic [23:0] w;
    logic [12:0] trig_ch;
    logic [7:0]  ev_dec;
    logic [3:0]  code;
    logic [31:0] count_wide;
    dfr_entry_t  ent;

    assign word_ready = !q_stat.full;
    assign accept     = word_valid && word_ready;
    assign w          = word_item.word;
    assign trig_ch    = 13'({module_id_reg, 5'b0});
    assign ev_dec     = events_left_reg - 8'd1;

    always_comb
    begin
        state_next       = state_reg;
        module_id_next   = module_id_reg;
        events_left_next = events_left_reg;
        adc_next         = adc_reg;
        count_next       = count_reg;
        err_next         = err_reg;
        code             = ERR_NONE;
        count_wide       = '0;
        ent              = '0;

        unique case (state_reg)
            ST_BLK_HDR:
            begin
                if (w[23:21] != 3'd0)
                begin
                    err_next   = ERR_BLK_HDR;
                    state_next = ST_DROP;
                end
                else
                begin
                    module_id_next   = w[20:16];
                    events_left_next = w[15:8];
                    state_next       = (w[15:8] != 8'd0) ? ST_EVT_HDR : ST_FILLER;
                end
            end
            ST_EVT_HDR:
            begin
                if (w[23:20] != 4'h4)
                begin
                    err_next   = ERR_EVT_HDR;
                    state_next = ST_DROP;
                end
                else
                begin
                    ent.rec_valid   = 1'b1;
                    ent.rec_kind    = KIND_EVENT;
                    ent.rec_channel = 13'({module_id_reg, 4'b0});
                    ent.rec_value   = w[19:0];
                    state_next      = ST_TRIG1;
                end
            end
            ST_TRIG1:
            begin
                // record goes out even when the tag is bad
                ent.rec_valid   = 1'b1;
                ent.rec_kind    = KIND_TRIG1;
                ent.rec_channel = trig_ch;
                ent.rec_value   = w[19:0];
                if (w[23:20] != 4'h6)
                begin
                    err_next   = ERR_TRIG1;
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_TRIG2;
                end
            end
            ST_TRIG2:
            begin
                ent.rec_valid   = 1'b1;
                ent.rec_kind    = KIND_TRIG2;
                ent.rec_channel = trig_ch;
                ent.rec_value   = w[19:0];
                if (w[23:20] != 4'h7)
                begin
                    err_next   = ERR_TRIG2;
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_FRAME_OR_END;
                end
            end
            ST_FRAME_OR_END:
            begin
                if (w[23:21] == 3'h4)
                begin
                    if (w[20:18] != 3'd0)
                    begin
                        err_next   = ERR_FRAME_HDR;
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        adc_next   = w[3:0];
                        state_next = ST_IN_FRAME;
                    end
                end
                else
                begin
                    // event trailer carries the fine trigger time
                    ent.rec_valid   = 1'b1;
                    ent.rec_kind    = KIND_FINE;
                    ent.rec_channel = trig_ch;
                    ent.rec_value   = 20'(w[7:0]);
                    if (w[23:20] != 4'hA)
                    begin
                        err_next   = ERR_EVT_TRL;
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        events_left_next = ev_dec;
                        state_next       = (ev_dec != 8'd0) ? ST_EVT_HDR : ST_FILLER;
                    end
                end
            end
            ST_IN_FRAME:
            begin
                if (w[20:19] == 2'b01)
                begin
                    ent.rec_valid   = 1'b1;
                    ent.rec_kind    = KIND_SAMPLE;
                    ent.rec_channel = {module_id_reg, 4'b0, adc_reg};
                    ent.rec_value   = 20'(w[11:0]);
                    if (count_reg != '1)
                        count_next = count_reg + COUNT_BITS'(1);
                end
                else if (w[20:17] != 4'h8)
                begin
                    err_next   = ERR_FRAME_TRL;
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_DATA_TRL;
                end
            end
            ST_DATA_TRL:
            begin
                if (w[20:19] != 2'b11)
                begin
                    err_next   = ERR_DATA_TRL;
                    state_next = ST_DROP;
                end
                else
                begin
                    state_next = ST_FRAME_OR_END;
                end
            end
            ST_FILLER:
            begin
                if (w != FILLER_WORD)
                begin
                    if (w[23:20] != 4'h2)
                    begin
                        err_next   = ERR_BLK_TRL;
                        state_next = ST_DROP;
                    end
                    else
                    begin
                        state_next = ST_BLK_HDR;
                    end
                end
            end
            default:
            begin
                // dropping until the buffer ends
            end
        endcase

        if (word_item.buffer_end)
        begin
            code = err_next;
            if (code == ERR_NONE && state_next != ST_BLK_HDR)
                code = ERR_TRUNC;
            // count includes a sample carried by this last word
            count_wide    = 32'(count_next);
            ent.sum_valid = 1'b1;
            ent.sum_code  = code;
            ent.sum_count = (count_wide > 32'hFFFF) ? 16'hFFFF : count_wide[15:0];

            state_next       = ST_BLK_HDR;
            module_id_next   = '0;
            events_left_next = '0;
            adc_next         = '0;
            count_next       = '0;
            err_next         = ERR_NONE;
        end
    end

    assign push       = accept && (ent.rec_valid || ent.sum_valid);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_BLK_HDR;
            module_id_reg   <= '0;
            events_left_reg <= '0;
            adc_reg         <= '0;
            count_reg       <= '0;
            err_reg         <= ERR_NONE;
        end
        else if (accept)
        begin
            state_reg       <= state_next;
            module_id_reg   <= module_id_next;
            events_left_reg <= events_left_next;
            adc_reg         <= adc_next;
            count_reg       <= count_next;
            err_reg         <= err_next;
        end
    end

endmodule

### sv/dfr_queue.sv
// ----------------------------------------------------------------------------
// dfr_queue
// Short FIFO of parsed transactions between the parser and the output stage.
// ----------------------------------------------------------------------------
module dfr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dfr_pkg::dfr_entry_t push_entry,
    input  logic                pop,
    output dfr_pkg::dfr_entry_t head,
    output dfr_pkg::dfr_qstat_t q_stat
);
    import dfr_pkg::*;

    dfr_entry_t        slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign q_stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### sv/dfr_back.sv
// ----------------------------------------------------------------------------
// dfr_back
// Output stage: expands each queued transaction into one or two result
// records and holds them in an output register.
// ----------------------------------------------------------------------------
module dfr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  dfr_pkg::dfr_entry_t head,
    input  dfr_pkg::dfr_qstat_t q_stat,
    output logic                pop,
    output logic                rec_valid,
    input  logic                rec_ready,
    output dfr_pkg::out_item_t  rec_item
);
    import dfr_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_item_t  out_reg, out_next;
    // head's data record already sent, summary still pending
    logic       rec_done_reg, rec_done_next;
    logic       load;
    logic       send_rec;

    assign load     = (!out_valid_reg || rec_ready) && !q_stat.empty;
    assign send_rec = head.rec_valid && !rec_done_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        rec_done_next  = rec_done_reg;
        pop            = 1'b0;

        if (out_valid_reg && rec_ready)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            if (send_rec)
            begin
                out_next.kind       = head.rec_kind;
                out_next.channel    = head.rec_channel;
                out_next.value      = head.rec_value;
                out_next.error_code = ERR_NONE;
                out_next.word_count = '0;
                out_next.last       = 1'b0;
                if (head.sum_valid)
                    rec_done_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                out_next.kind       = (head.sum_code == ERR_NONE) ? KIND_OK : KIND_ERR;
                out_next.channel    = '0;
                out_next.value      = '0;
                out_next.error_code = head.sum_code;
                out_next.word_count = head.sum_count;
                out_next.last       = 1'b1;
                rec_done_next       = 1'b0;
                pop                 = 1'b1;
            end
        end
    end

    assign rec_valid = out_valid_reg;
    assign rec_item  = out_reg;

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rec_done_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            rec_done_reg  <= rec_done_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_summary_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_item.last) |-> (rec_item.kind == KIND_OK || rec_item.kind == KIND_ERR))
        else $error("summary record with data kind");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && !rec_item.last) |->
            (rec_item.error_code == ERR_NONE && rec_item.word_count == '0 &&
             rec_item.kind <= KIND_SAMPLE))
        else $error("data record carries summary fields");

    a_ok_no_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_item.kind == KIND_OK) |-> (rec_item.error_code == ERR_NONE))
        else $error("ok summary with error code");

    a_pending_summary: assert property (@(posedge clk) disable iff (!rst_n)
        rec_done_reg |-> (!q_stat.empty && head.sum_valid))
        else $error("pending summary lost from queue head");
`endif

endmodule

### sv/daq_block_word_deframer.sv
// ----------------------------------------------------------------------------
// daq_block_word_deframer
// Block / event / sample frame parser for 24-bit readout words; emits
// channel/value records and a per-buffer summary.
// ----------------------------------------------------------------------------
//  channel | valid      | ready      | payload
//  words   | word_valid | word_ready | word_item (word, buffer_end)
//  records | rec_valid  | rec_ready  | rec_item  (kind .. last)
//
//  One word per cycle is accepted while the 4-entry transaction queue has room.
//  The last word of a buffer that also yields a data record gives two records
//  in the output stage: the data record first, then the buffer summary.
//  Records are registered from the queue head whenever the output is free.
//  Reset returns the parser to expect a block header, queue and output empty.
// ----------------------------------------------------------------------------
module daq_block_word_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               word_valid,
    output logic               word_ready,
    input  dfr_pkg::in_item_t  word_item,
    output logic               rec_valid,
    input  logic               rec_ready,
    output dfr_pkg::out_item_t rec_item
);
    import dfr_pkg::*;

    logic       push;
    logic       pop;
    dfr_entry_t push_entry;
    dfr_entry_t head;
    dfr_qstat_t q_stat;

    dfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_item  (word_item),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    dfr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    dfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .rec_valid (rec_valid),
        .rec_ready (rec_ready),
        .rec_item  (rec_item)
    );

endmodule

### bench/daq_block_word_deframer_tb.sv
// ----------------------------------------------------------------------------
// daq_block_word_deframer_tb
// Self-checking bench for the block word deframer. Readout buffers are
// built as framed block/event/sample sequences with random content, some
// corrupted, cut short or replaced by noise. They are streamed in with
// random gaps while the record side stalls at random. Every accepted word
// goes through a parser model that queues the records it should produce.
// Each record taken from the block is compared field by field with the
// oldest queued one.
// ----------------------------------------------------------------------------
module daq_block_word_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dfr_pkg::*;

    localparam int RANDOM_WORDS = 1400;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_PRINTED  = 40;

    // framing tags
    localparam logic [3:0] TAG_EVT_HDR    = 4'h4;
    localparam logic [3:0] TAG_TRIG1      = 4'h6;
    localparam logic [3:0] TAG_TRIG2      = 4'h7;
    localparam logic [3:0] TAG_EVT_TRL    = 4'hA;
    localparam logic [3:0] TAG_BLK_TRL    = 4'h2;
    localparam logic [2:0] TAG_BLK_HDR    = 3'b000;
    localparam logic [2:0] TAG_FRAME      = 3'b100;
    localparam logic [1:0] MARK_SAMPLE    = 2'b01;
    localparam logic [3:0] MARK_FRAME_TRL = 4'b1000;
    localparam logic [1:0] MARK_DATA_TRL  = 2'b11;

    class record_scoreboard;
        logic [3:0]            parse_state;
        logic [4:0]            module_id;
        logic [7:0]            events_left;
        logic [3:0]            adc_channel;
        logic [COUNT_BITS-1:0] sample_total;
        logic [3:0]            error_code;
        out_item_t             expected_records[$];
        int                    mismatches;

        function new();
            mismatches = 0;
            rearm();
        endfunction

        function void rearm();
            parse_state  = ST_BLK_HDR;
            module_id    = '0;
            events_left  = '0;
            adc_channel  = '0;
            sample_total = '0;
            error_code   = ERR_NONE;
        endfunction

        function int pending();
            return expected_records.size();
        endfunction

        function void queue_record(logic [2:0] kind, logic [12:0] channel,
                                   logic [19:0] value, logic [3:0] code,
                                   logic [15:0] count, logic last_flag);
            out_item_t r;
            r.kind       = kind;
            r.channel    = channel;
            r.value      = value;
            r.error_code = code;
            r.word_count = count;
            r.last       = last_flag;
            expected_records.push_back(r);
        endfunction

        function void abort(logic [3:0] code);
            error_code  = code;
            parse_state = ST_DROP;
        endfunction

        // Returns 1 when the word was parsed rather than dropped.
        function bit parse_word(in_item_t item);
            logic [23:0]     w;
            logic [12:0]     trig_ch;
            logic [3:0]      code;
            longint unsigned wide;
            bit              parsed;
            w       = item.word;
            trig_ch = {3'b000, module_id, 5'b00000};
            parsed  = (parse_state != ST_DROP);
            case (parse_state)
                ST_BLK_HDR:
                    if (w[23:21] != TAG_BLK_HDR) abort(ERR_BLK_HDR);
                    else
                    begin
                        module_id   = w[20:16];
                        events_left = w[15:8];
                        parse_state = (events_left != 0) ? ST_EVT_HDR : ST_FILLER;
                    end
                ST_EVT_HDR:
                    if (w[23:20] != TAG_EVT_HDR) abort(ERR_EVT_HDR);
                    else
                    begin
                        queue_record(KIND_EVENT, {4'b0000, module_id, 4'b0000},
                                     w[19:0], ERR_NONE, 16'd0, 1'b0);
                        parse_state = ST_TRIG1;
                    end
                ST_TRIG1:
                begin
                    // record goes out before the tag is looked at
                    queue_record(KIND_TRIG1, trig_ch, w[19:0], ERR_NONE, 16'd0, 1'b0);
                    if (w[23:20] != TAG_TRIG1) abort(ERR_TRIG1);
                    else parse_state = ST_TRIG2;
                end
                ST_TRIG2:
                begin
                    queue_record(KIND_TRIG2, trig_ch, w[19:0], ERR_NONE, 16'd0, 1'b0);
                    if (w[23:20] != TAG_TRIG2) abort(ERR_TRIG2);
                    else parse_state = ST_FRAME_OR_END;
                end
                ST_FRAME_OR_END:
                    if (w[23:21] == TAG_FRAME)
                    begin
                        if (w[20:18] != 3'b000) abort(ERR_FRAME_HDR);
                        else
                        begin
                            adc_channel = w[3:0];
                            parse_state = ST_IN_FRAME;
                        end
                    end
                    else
                    begin
                        queue_record(KIND_FINE, trig_ch, {12'd0, w[7:0]},
                                     ERR_NONE, 16'd0, 1'b0);
                        if (w[23:20] != TAG_EVT_TRL) abort(ERR_EVT_TRL);
                        else
                        begin
                            events_left = events_left - 8'd1;
                            parse_state = (events_left != 0) ? ST_EVT_HDR : ST_FILLER;
                        end
                    end
                ST_IN_FRAME:
                    if (w[20:19] == MARK_SAMPLE)
                    begin
                        queue_record(KIND_SAMPLE, {module_id, 4'b0000, adc_channel},
                                     {8'd0, w[11:0]}, ERR_NONE, 16'd0, 1'b0);
                        if (sample_total != {COUNT_BITS{1'b1}})
                            sample_total = sample_total + 1'b1;
                    end
                    else if (w[20:17] != MARK_FRAME_TRL) abort(ERR_FRAME_TRL);
                    else parse_state = ST_DATA_TRL;
                ST_DATA_TRL:
                    if (w[20:19] != MARK_DATA_TRL) abort(ERR_DATA_TRL);
                    else parse_state = ST_FRAME_OR_END;
                ST_FILLER:
                    if (w != FILLER_WORD)
                    begin
                        if (w[23:20] != TAG_BLK_TRL) abort(ERR_BLK_TRL);
                        else parse_state = ST_BLK_HDR;
                    end
                default: ;
            endcase

            if (item.buffer_end)
            begin
                code = error_code;
                wide = sample_total;
                if (code == ERR_NONE && parse_state != ST_BLK_HDR) code = ERR_TRUNC;
                queue_record((code == ERR_NONE) ? KIND_OK : KIND_ERR, 13'd0, 20'd0, code,
                             (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0], 1'b1);
                rearm();
            end
            return parsed;
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
        endtask

        task compare_field(string name, int got, int want);
            if (got != want)
                report($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_record(out_item_t got);
            out_item_t want;
            if (expected_records.size() == 0)
            begin
                report($sformatf("unexpected record kind=%0d channel=0x%0h value=0x%0h",
                                 got.kind, got.channel, got.value));
                return;
            end
            want = expected_records.pop_front();
            compare_field("kind", got.kind, want.kind);
            compare_field("channel", got.channel, want.channel);
            compare_field("value", got.value, want.value);
            compare_field("error_code", got.error_code, want.error_code);
            compare_field("word_count", got.word_count, want.word_count);
            compare_field("last", got.last, want.last);
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      word_valid;
    logic      word_ready;
    in_item_t  word_item;
    logic      rec_valid;
    logic      rec_ready;
    out_item_t rec_item;

    record_scoreboard sb;
    logic [23:0]      plan_q[$];
    int               parsed_words;
    bit               quiet_in;

    daq_block_word_deframer DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word_item  (word_item),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_item   (rec_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_word(input logic [23:0] w, input logic last_word);
        in_item_t item;
        int       gap;
        item.word       = w;
        item.buffer_end = last_word;
        gap = quiet_in ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            word_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_valid <= 1'b1;
        word_item  <= item;
        // inputs only move at the rising edge, so the negedge view holds
        // for the coming edge
        do @(negedge clk); while (!word_ready);
        if (sb.parse_word(item)) parsed_words++;
        @(posedge clk);
    endtask

    task automatic send_plan();
        foreach (plan_q[i]) send_word(plan_q[i], i == plan_q.size() - 1);
        plan_q.delete();
    endtask

    // One buffer: mostly well-formed blocks, sometimes damaged.
    function automatic void plan_buffer();
        int         nev;
        int         cut;
        int         pick;
        int         idx;
        logic [4:0] id;
        plan_q.delete();
        if ($urandom_range(0, 19) == 0)
        begin
            repeat ($urandom_range(1, 6)) plan_q.push_back(24'($urandom));
            return;
        end
        repeat (($urandom_range(0, 4) == 0) ? 2 : 1)
        begin
            nev = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
            id  = 5'($urandom);
            plan_q.push_back({TAG_BLK_HDR, id, 8'(nev), 8'($urandom)});
            repeat (nev)
            begin
                plan_q.push_back({TAG_EVT_HDR, 20'($urandom)});
                plan_q.push_back({TAG_TRIG1, 20'($urandom)});
                plan_q.push_back({TAG_TRIG2, 20'($urandom)});
                repeat ($urandom_range(0, 3))
                begin
                    plan_q.push_back({TAG_FRAME, 3'b000, 18'($urandom)});
                    repeat ($urandom_range(0, 6))
                        plan_q.push_back({3'($urandom), MARK_SAMPLE, 19'($urandom)});
                    plan_q.push_back({3'($urandom), MARK_FRAME_TRL, 17'($urandom)});
                    plan_q.push_back({3'($urandom), MARK_DATA_TRL, 19'($urandom)});
                end
                plan_q.push_back({TAG_EVT_TRL, 20'($urandom)});
            end
            repeat ($urandom_range(0, 2)) plan_q.push_back(FILLER_WORD);
            plan_q.push_back({TAG_BLK_TRL, 20'($urandom)});
        end
        pick = $urandom_range(0, 9);
        idx  = $urandom_range(0, plan_q.size() - 1);
        if (pick < 2) plan_q[idx] = 24'($urandom);
        else if (pick == 2) plan_q[idx] = plan_q[idx] ^ (24'd1 << $urandom_range(17, 23));
        else if (pick == 3)
        begin
            cut = $urandom_range(1, plan_q.size() - 1);
            while (plan_q.size() > cut) void'(plan_q.pop_back());
        end
    endfunction

    initial
    begin : record_sink
        out_item_t got;
        int        stall;
        bit        quiet_out;
        rec_ready = 1'b0;
        quiet_out = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0) quiet_out = !quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                rec_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rec_ready <= 1'b1;
            do @(negedge clk); while (!rec_valid);
            got = rec_item;
            @(posedge clk);
            sb.check_record(got);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if ((word_valid && word_ready) || (rec_valid && rec_ready)) idle = 0;
            else idle++;
            if (idle >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        sb           = new();
        rst_n        = 1'b0;
        word_valid   = 1'b0;
        word_item    = '0;
        quiet_in     = 1'b0;
        parsed_words = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // block with no events: filler then trailer
        plan_q = '{24'h000000, FILLER_WORD, 24'h2FFFFF};
        send_plan();
        // one event, all-ones fields plus a zero sample, module 31, channel 15
        plan_q = '{24'h1F01FF, 24'h4FFFFF, 24'h6FFFFF, 24'h7FFFFF, 24'h83FFFF,
                   24'hEFFFFF, 24'h080000, 24'hF1FFFF, 24'hFFFFFF, 24'hAFFFFF,
                   24'h2FFFFF};
        send_plan();
        // bad block header, rest dropped
        plan_q = '{24'hFFFFFF, 24'h4FFFFF};
        send_plan();
        // bad trigger tag on the last word: record plus summary
        plan_q = '{24'h000100, 24'h400000, 24'h000000};
        send_plan();
        // buffer cut short right after a 255-event header
        plan_q = '{24'h00FF00};
        send_plan();
        // frame header with bad tag bits
        plan_q = '{24'h010100, 24'h412345, 24'h6AAAAA, 24'h755555, 24'h9C0000};
        send_plan();

        parsed_words = 0;
        while (parsed_words < RANDOM_WORDS)
        begin
            quiet_in = ($urandom_range(0, 4) == 0);
            plan_buffer();
            send_plan();
        end
        quiet_in = 1'b0;

        word_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
